// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check at every rising edge, ignore cycles in reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check at every rising edge, reset cycles included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Sizes, codes, types and helpers of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_DIM   = 16;
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int K_W       = $clog2(MAX_DIM);
    localparam int AW        = $clog2(MAX_DIM * MAX_DIM);
    localparam int ROW_LIMIT = 4096;
    localparam int ROWS_W    = 13;
    localparam int POS_W     = 12;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int ACC_W     = 40;
    localparam int REG_DIM_W = 5;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_A    = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic signed [VAL_W-1:0] value;
        logic [AW-1:0]           addr;
        logic                    row_end;
        logic                    mat_end;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return DIM_W'(v);
        end
    endfunction

    function automatic logic [ROWS_W-1:0] clamp_rows(input logic [ROWS_W-1:0] v);
        if (v == '0) begin
            return ROWS_W'(1);
        end else if (32'(v) > ROW_LIMIT) begin
            return ROWS_W'(ROW_LIMIT);
        end else begin
            return v;
        end
    endfunction

endpackage

// ===== rtl/mme_ram.sv =====
// ----------------------------------------------------------------------------
// mme_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mme_front.sv =====
// ----------------------------------------------------------------------------
// mme_front
// Configuration registers and input side: classify each request, track the
// B load pointer and the A row and column positions, queue a command.
// ----------------------------------------------------------------------------
module mme_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_s_valid,
    output logic                           o_s_ready,
    input  logic [mme_pkg::VAL_W-1:0]      i_s_value,
    input  logic                           i_s_mode,
    input  logic                           i_q_full,
    output mme_pkg::t_push                 o_push,
    output logic [mme_pkg::DIM_W-1:0]      o_cols
);
    import mme_pkg::*;

    logic [REG_DIM_W-1:0] r_inner;
    logic [REG_DIM_W-1:0] r_cols;
    logic [ROWS_W-1:0]    r_rows;
    logic [AW-1:0]        r_bptr;
    logic [K_W-1:0]       r_ipos;
    logic [POS_W-1:0]     r_rpos;

    logic [DIM_W-1:0]  w_inner;
    logic [DIM_W-1:0]  w_cols;
    logic [ROWS_W-1:0] w_rows;
    logic [AW:0]       w_size;
    logic [AW-1:0]     w_ptr_eff;
    logic [AW:0]       w_ptr_inc;
    logic [AW-1:0]     n_bptr;
    logic [K_W-1:0]    w_k;
    logic [DIM_W-1:0]  w_ipos_inc;
    logic              w_row_end;
    logic              w_mat_end;
    logic              w_accept;

    assign w_inner = clamp_dim(r_inner);
    assign w_cols  = clamp_dim(r_cols);
    assign w_rows  = clamp_rows(r_rows);
    assign o_cols  = w_cols;

    assign w_size    = (AW+1)'(w_inner) * (AW+1)'(w_cols);
    assign w_ptr_eff = ({1'b0, r_bptr} >= w_size) ? '0 : r_bptr;
    assign w_ptr_inc = {1'b0, w_ptr_eff} + (AW+1)'(1);
    assign n_bptr    = (w_ptr_inc >= w_size) ? '0 : w_ptr_inc[AW-1:0];

    assign w_k        = (DIM_W'(r_ipos) < w_inner) ? r_ipos : K_W'(w_inner - DIM_W'(1));
    assign w_ipos_inc = DIM_W'(r_ipos) + DIM_W'(1);
    assign w_row_end  = w_ipos_inc >= w_inner;
    assign w_mat_end  = (ROWS_W'(r_rpos) + ROWS_W'(1)) >= w_rows;

    assign o_s_ready = !i_q_full;
    assign w_accept  = i_s_valid && o_s_ready;

    always_comb begin
        o_push.push        = w_accept;
        o_push.cmd.mode    = i_s_mode;
        o_push.cmd.value   = i_s_value;
        o_push.cmd.addr    = (i_s_mode == MODE_LOAD) ? w_ptr_eff : AW'(w_k);
        o_push.cmd.row_end = (i_s_mode == MODE_A) && w_row_end;
        o_push.cmd.mat_end = (i_s_mode == MODE_A) && w_row_end && w_mat_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= REG_DIM_W'(1);
            r_cols  <= REG_DIM_W'(1);
            r_rows  <= ROWS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INNER: begin
                    r_inner <= i_cfg_data[REG_DIM_W-1:0];
                end
                CFG_COLS: begin
                    r_cols <= i_cfg_data[REG_DIM_W-1:0];
                end
                CFG_ROWS: begin
                    r_rows <= i_cfg_data[ROWS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bptr <= '0;
            r_ipos <= '0;
            r_rpos <= '0;
        end else if (w_accept) begin
            if (i_s_mode == MODE_LOAD) begin
                r_bptr <= n_bptr;
            end else if (w_row_end) begin
                r_ipos <= '0;
                r_rpos <= w_mat_end ? '0 : r_rpos + POS_W'(1);
            end else begin
                r_ipos <= r_ipos + K_W'(1);
            end
        end
    end

endmodule

// ===== rtl/mme_queue.sv =====
// ----------------------------------------------------------------------------
// mme_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module mme_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mme_pkg::t_push i_push,
    output logic           o_full,
    output mme_pkg::t_head o_head,
    input  logic           i_pop
);
    import mme_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full       = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_head.valid = r_cnt != '0;
    assign o_head.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            priority if (i_push.push && !i_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push.push) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end else begin
            end
        end
    end

endmodule

// ===== rtl/mme_back.sv =====
// ----------------------------------------------------------------------------
// mme_back
// Execution side: B store writes, one shared multiply-accumulate stepping
// over the product columns, row accumulators and the output register.
// ----------------------------------------------------------------------------
module mme_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mme_pkg::DIM_W-1:0]   i_cols,
    input  mme_pkg::t_head              i_head,
    output logic                        o_pop,
    output logic                        o_m_valid,
    input  logic                        i_m_ready,
    output logic [mme_pkg::ACC_W-1:0]   o_m_product,
    output logic                        o_m_last_row,
    output logic                        o_m_last_mat
);
    import mme_pkg::*;

    logic                     r_busy;
    logic [K_W-1:0]           r_j;
    logic [AW-1:0]            r_base;
    logic signed [VAL_W-1:0]  r_val;
    logic                     r_row_end;
    logic                     r_mat_end;

    logic                     r_s1_valid;
    logic [K_W-1:0]           r_s1_j;
    logic signed [VAL_W-1:0]  r_s1_val;
    logic                     r_s1_row_end;
    logic                     r_s1_mat_end;
    logic                     r_s1_last;

    logic                     r_s2_valid;
    logic [K_W-1:0]           r_s2_j;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic                     r_s2_row_end;
    logic                     r_s2_mat_end;
    logic                     r_s2_last;

    logic [ACC_W-1:0]         r_acc [MAX_DIM];

    logic                     r_out_valid;
    logic [ACC_W-1:0]         r_out_product;
    logic                     r_out_last_row;
    logic                     r_out_last_mat;

    logic                     w_adv;
    logic                     w_last_issue;
    logic                     w_pop_a;
    logic                     w_ram_we;
    logic [AW-1:0]            w_raddr;
    logic [VAL_W-1:0]         w_rdata;
    logic [ACC_W-1:0]         w_sum;

    assign w_adv        = !r_out_valid || i_m_ready;
    assign w_last_issue = r_busy && (DIM_W'(r_j) == i_cols - DIM_W'(1));
    assign o_pop        = w_adv && i_head.valid && (!r_busy || w_last_issue);
    assign w_pop_a      = o_pop && (i_head.cmd.mode == MODE_A);
    assign w_ram_we     = o_pop && (i_head.cmd.mode == MODE_LOAD);
    assign w_raddr      = r_base + AW'(r_j);

    mme_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_b_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_head.cmd.addr),
        .i_wdata (i_head.cmd.value),
        .i_re    (w_adv),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_sum = r_acc[r_s2_j] + {{(ACC_W-PROD_W){r_s2_prod[PROD_W-1]}}, r_s2_prod};

    // sequencer and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_j         <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= r_busy;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_row_end;
            priority if (w_pop_a) begin
                r_busy <= 1'b1;
                r_j    <= '0;
            end else if (w_last_issue) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_j <= r_j + K_W'(1);
            end else begin
            end
        end
    end

    // accumulators: clear after each emitted row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DIM; i++) begin
                r_acc[i] <= '0;
            end
        end else if (w_adv && r_s2_valid) begin
            r_acc[r_s2_j] <= r_s2_row_end ? '0 : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_a) begin
            r_base    <= AW'(i_head.cmd.addr) * AW'(i_cols);
            r_val     <= i_head.cmd.value;
            r_row_end <= i_head.cmd.row_end;
            r_mat_end <= i_head.cmd.mat_end;
        end
        if (w_adv) begin
            r_s1_j       <= r_j;
            r_s1_val     <= r_val;
            r_s1_row_end <= r_row_end;
            r_s1_mat_end <= r_mat_end;
            r_s1_last    <= w_last_issue;

            r_s2_j       <= r_s1_j;
            r_s2_prod    <= r_s1_val * $signed(w_rdata);
            r_s2_row_end <= r_s1_row_end;
            r_s2_mat_end <= r_s1_mat_end;
            r_s2_last    <= r_s1_last;

            r_out_product  <= w_sum;
            r_out_last_row <= r_s2_last;
            r_out_last_mat <= r_s2_last && r_s2_mat_end;
        end
    end

    assign o_m_valid    = r_out_valid;
    assign o_m_product  = r_out_product;
    assign o_m_last_row = r_out_last_row;
    assign o_m_last_mat = r_out_last_mat;

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
// Pipeline: sequencer, stage 1 with the B store read, product and output registers.
// A C row starts once its last A element is taken while the back end is free, then
// gives one element a cycle while the output is not held. The single shared
// multiply-accumulate steps over the product columns; the next A element or B load
// is taken as the last column issues. Reset: synchronous, active low; clears
// positions and accumulators, sets the registers to 1. The B store is not cleared.
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Streaming C = A x B in signed fixed point: B loaded into a store, A rows
// streamed, each finished C row emitted in column order.
// ----------------------------------------------------------------------------
module matrix_multiply_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // [15:0] value
    input  logic                          s_axis_tuser,  // [0] mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,  // [39:0] product
    output logic                          m_axis_tlast,
    output logic                          m_axis_tuser   // [0] last_in_matrix
);
    import mme_pkg::*;

    t_push            w_push;
    t_head            w_head;
    logic             w_full;
    logic             w_pop;
    logic [DIM_W-1:0] w_cols;

    mme_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_s_value  (s_axis_tdata),
        .i_s_mode   (s_axis_tuser),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_cols     (w_cols)
    );

    mme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    mme_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cols       (w_cols),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_m_product  (m_axis_tdata),
        .o_m_last_row (m_axis_tlast),
        .o_m_last_mat (m_axis_tuser)
    );

endmodule

// ===== rtl/mme_checker.sv =====
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks of the matrix multiply engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    property p_mat_end;
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast;
    endproperty

    property p_out_hold;
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
             $stable(m_axis_tuser));
    endproperty

    `ASSERT_CLK(a_mat_end_ends_row, p_mat_end, "matrix end without row end")
    `ASSERT_CLK(a_out_hold, p_out_hold, "held result changed")
    `ASSERT_ALWAYS(a_reset_no_out, !i_rst_n |=> !m_axis_tvalid, "result shown after reset")
    `ASSERT_ALWAYS(a_reset_ready, !i_rst_n |=> s_axis_tready, "input not ready after reset")

endmodule

bind matrix_multiply_engine mme_checker u_checker (.*);

// ===== test/matrix_multiply_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine_tb
// Self-checking bench for the streaming matrix multiply. B and A elements go
// in through the input stream. A bit-exact row accumulator predicts each C
// row, and every product leaving the output stream is checked in order.
// Directed cases cover field extremes, register saturation, stale positions,
// mixed loads and one long output hold-off. Random phases with random sizes
// follow, back to back first, then with idle cycles on both sides.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_tb;

    import mme_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 420;

    typedef struct packed {
        logic [ACC_W-1:0] product;
        logic             last_row;
        logic             last_mat;
    } t_product;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata  = '0;  // [15:0] value
    logic                 s_axis_tuser  = 1'b0; // [0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;        // [39:0] product
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;        // [0] last_in_matrix

    // predictor state
    logic [REG_DIM_W-1:0]    reg_inner_len;
    logic [REG_DIM_W-1:0]    reg_out_cols;
    logic [ROWS_W-1:0]       reg_a_rows;
    logic signed [VAL_W-1:0] b_mem [MAX_DIM*MAX_DIM];
    logic signed [ACC_W-1:0] row_acc [MAX_DIM];
    int unsigned             load_ptr;
    int unsigned             inner_pos;
    int unsigned             row_pos;
    t_product                pending_products[$];

    int   items_sent  = 0;
    int   mismatches  = 0;
    int   stuck       = 0;
    int   hold_left   = 0;
    logic calm        = 1'b0;
    logic stall_req   = 1'b0;
    logic stall_seen  = 1'b0;
    t_product want;

    matrix_multiply_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned dim_of(input logic [REG_DIM_W-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (int'(v) > MAX_DIM) begin
            return MAX_DIM;
        end
        return v;
    endfunction

    function automatic int unsigned rows_of(input logic [ROWS_W-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (int'(v) > ROW_LIMIT) begin
            return ROW_LIMIT;
        end
        return v;
    endfunction

    function automatic void clear_model();
        reg_inner_len = 1;
        reg_out_cols  = 1;
        reg_a_rows    = 1;
        load_ptr      = 0;
        inner_pos     = 0;
        row_pos       = 0;
        foreach (b_mem[i]) b_mem[i] = '0;
        foreach (row_acc[i]) row_acc[i] = '0;
    endfunction

    function automatic void accumulate_request(input logic mode,
                                               input logic signed [VAL_W-1:0] value);
        int unsigned inner;
        int unsigned cols;
        int unsigned size;
        int unsigned k;
        int unsigned j;
        logic signed [PROD_W-1:0] prod;
        logic row_done;
        logic mat_done;
        t_product r;
        inner = dim_of(reg_inner_len);
        cols  = dim_of(reg_out_cols);
        if (mode == MODE_LOAD) begin
            size = inner * cols;
            if (load_ptr >= size) load_ptr = 0;
            b_mem[load_ptr] = value;
            load_ptr = (load_ptr + 1 >= size) ? 0 : load_ptr + 1;
            return;
        end
        k = (inner_pos < inner) ? inner_pos : inner - 1;
        row_done = (inner_pos + 1 >= inner);
        for (j = 0; j < cols; j++) begin
            prod = value * b_mem[k*cols + j];
            row_acc[j] = row_acc[j] + prod;
        end
        if (!row_done) begin
            inner_pos++;
            return;
        end
        inner_pos = 0;
        mat_done = (row_pos + 1 >= rows_of(reg_a_rows));
        for (j = 0; j < cols; j++) begin
            r.product  = row_acc[j];
            r.last_row = (j == cols - 1);
            r.last_mat = (j == cols - 1) && mat_done;
            pending_products.push_back(r);
            row_acc[j] = '0;
        end
        row_pos = mat_done ? 0 : row_pos + 1;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        if ($urandom_range(99) < 20) begin
            case ($urandom_range(3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return VAL_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] dim_word(input int unsigned v);
        return {8'($urandom), 5'(v)};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_INNER: reg_inner_len = data[REG_DIM_W-1:0];
            CFG_COLS:  reg_out_cols  = data[REG_DIM_W-1:0];
            CFG_ROWS:  reg_a_rows    = data;
            default:   ;
        endcase
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] inner, input logic [CFG_W-1:0] cols,
                            input logic [CFG_W-1:0] rows);
        write_reg(CFG_INNER, inner);
        write_reg(CFG_COLS, cols);
        write_reg(CFG_ROWS, rows);
        end_writes();
    endtask

    task automatic send_item(input logic mode, input logic [VAL_W-1:0] value);
        int gap;
        gap = (!calm && $urandom_range(99) < 33) ? $urandom_range(1, 4) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        accumulate_request(mode, value);
        items_sent++;
    endtask

    task automatic load_b_full();
        repeat (dim_of(reg_inner_len) * dim_of(reg_out_cols)) send_item(MODE_LOAD, rand_value());
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_item(MODE_LOAD, 16'h8000);
        send_item(MODE_A, 16'h8000);
        send_item(MODE_A, 16'h7FFF);
        send_item(MODE_A, 16'h0000);
        wait_idle();
    endtask

    task automatic test_saturation_and_unused_index();
        write_reg(CFG_INNER, 13'h1FE0);
        write_reg(CFG_COLS, dim_word(2));
        write_reg(CFG_ROWS, 13'h0000);
        write_reg(CFG_UNUSED, 13'h1FFF);
        end_writes();
        send_item(MODE_LOAD, 16'h7FFF);
        send_item(MODE_LOAD, 16'h8000);
        send_item(MODE_A, 16'h8000);
        send_item(MODE_A, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_stale_positions();
        set_dims(dim_word(2), dim_word(2), 13'd3);
        repeat (4) send_item(MODE_LOAD, rand_value());
        repeat (3) send_item(MODE_LOAD, rand_value());
        send_item(MODE_A, rand_value());
        send_item(MODE_LOAD, rand_value());
        send_item(MODE_A, rand_value());
        send_item(MODE_A, rand_value());
        wait_idle();
        // shrink the sizes under a part-filled row
        set_dims(dim_word(1), dim_word(2), 13'd1);
        send_item(MODE_LOAD, rand_value());
        send_item(MODE_LOAD, rand_value());
        send_item(MODE_A, rand_value());
        wait_idle();
    endtask

    task automatic run_phase();
        int unsigned inner_v;
        int unsigned cols_v;
        logic [CFG_W-1:0] rows_w;
        int unsigned sel;
        int unsigned n_rows;
        sel = $urandom_range(9);
        inner_v = $urandom_range(0, 4);
        cols_v  = $urandom_range(0, 4);
        if (sel == 0) begin
            inner_v = ($urandom_range(1)) ? 16 : $urandom_range(17, 31);
            cols_v  = $urandom_range(1, 2);
        end else if (sel == 1) begin
            cols_v  = ($urandom_range(1)) ? 16 : $urandom_range(17, 31);
            inner_v = $urandom_range(1, 2);
        end
        rows_w = CFG_W'($urandom_range(0, 5));
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
                0:       rows_w = 13'd4096;
                1:       rows_w = 13'h1FFF;
                default: rows_w = CFG_W'($urandom);
            endcase
        end
        set_dims(dim_word(inner_v), dim_word(cols_v), rows_w);
        load_b_full();
        n_rows = $urandom_range(1, 4);
        repeat (n_rows * dim_of(reg_inner_len)) begin
            if ($urandom_range(9) == 0) send_item(MODE_LOAD, rand_value());
            send_item(MODE_A, rand_value());
        end
        // now and then send extra A elements, which may leave a broken row behind
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, dim_of(reg_inner_len))) send_item(MODE_A, rand_value());
        end
        wait_idle();
    endtask

    task automatic test_back_to_back();
        int start;
        start = items_sent;
        calm <= 1'b1;
        while (items_sent - start < 60) run_phase();
        calm <= 1'b0;
    endtask

    task automatic test_output_hold_off();
        set_dims(dim_word(1), dim_word(16), 13'd3);
        load_b_full();
        stall_req <= ~stall_req;
        repeat (30) send_item(MODE_A, rand_value());
        wait_idle();
    endtask

    task automatic test_random_phases();
        while (items_sent < ITEM_TARGET) run_phase();
    endtask

    always @(posedge i_clk) begin
        if (stall_req != stall_seen) begin
            stall_seen    <= stall_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_products.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected product %h last_row %b last_mat %b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end else begin
                want = pending_products.pop_front();
                if (m_axis_tdata !== want.product || m_axis_tlast !== want.last_row ||
                    m_axis_tuser !== want.last_mat) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("product exp %h/%b/%b got %h/%b/%b",
                                 want.product, want.last_row, want.last_mat,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck <= 0;
        end else if (stuck >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        clear_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_saturation_and_unused_index();
        test_stale_positions();
        test_output_hold_off();
        test_back_to_back();
        test_random_phases();
        wait_idle();
        if (mismatches == 0 && pending_products.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
